// File: design/fdrp_pkg.sv
// fdrp_pkg: shared types and constants for the flooding router with duplicate suppression
// holds the table geometry, field widths, status codes, sequencer states and the table entry
// no dependencies
package fdrp_pkg;

	localparam int TABLE_DEPTH = 64;
	localparam int PORT_COUNT  = 16;

	localparam int ADDR_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);

	localparam int FLOW_W   = 64;
	localparam int TTL_W    = 8;
	localparam int PORT_W   = 4;
	localparam int STATUS_W = 3;

	typedef enum logic [STATUS_W-1:0] {
		ST_NEW     = 3'd0,
		ST_DUP     = 3'd1,
		ST_UNKNOWN = 3'd2,
		ST_LOCAL   = 3'd3,
		ST_RELAYED = 3'd4,
		ST_EXPIRED = 3'd5
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_DECIDE
	} seq_state_t;

	localparam logic FUNC_REQUEST  = 1'b0;
	localparam logic FUNC_RESPONSE = 1'b1;

	typedef struct packed {
		logic [FLOW_W-1:0] flow_id;
		logic [PORT_W-1:0] hop_port;
		logic              own;
	} entry_t;

endpackage

// File: design/fdrp_table.sv
// fdrp_table: flow table memory, one write port and one read port with registered read data
// depends on fdrp_pkg for the entry type and address width
module fdrp_table (
	input  logic                        clk,
	input  logic                        wr_en,
	input  logic [fdrp_pkg::ADDR_W-1:0] wr_addr,
	input  fdrp_pkg::entry_t            wr_data,
	input  logic                        rd_en,
	input  logic [fdrp_pkg::ADDR_W-1:0] rd_addr,
	output fdrp_pkg::entry_t            rd_data
);
	import fdrp_pkg::*;

	entry_t mem [TABLE_DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// File: design/flood_dedup_reverse_path_router.sv
// flood_dedup_reverse_path_router: one item per header, one result per item, marked by done
// search: the single comparator walks the filled table entries one per cycle,
// and a match at entry i ends the walk early at that entry
// throughput: one item at a time, busy is high from the accepting edge until done
// reset clears the sequencer, write pointer and fill count; table contents stay undefined
module flood_dedup_reverse_path_router (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic                          func,
	input  logic [fdrp_pkg::FLOW_W-1:0]   flow_id,
	input  logic [fdrp_pkg::TTL_W-1:0]    ttl,
	input  logic                          from_local,
	input  logic [fdrp_pkg::PORT_W-1:0]   sender_port,
	output logic                          done,
	output logic [fdrp_pkg::STATUS_W-1:0] status,
	output logic                          deliver_local,
	output logic                          flood_out,
	output logic                          exclude_valid,
	output logic                          unicast_out,
	output logic [fdrp_pkg::PORT_W-1:0]   out_port,
	output logic [fdrp_pkg::TTL_W-1:0]    out_ttl
);
	import fdrp_pkg::*;

	seq_state_t state_q, state_d;

	// latched item
	logic              func_q;
	logic [FLOW_W-1:0] flow_id_q;
	logic [TTL_W-1:0]  ttl_q;
	logic              local_q;
	logic [PORT_W-1:0] port_q;

	logic [CNT_W-1:0]  idx_q;
	logic [CNT_W-1:0]  fill_q;
	logic [ADDR_W-1:0] wp_q;
	logic              found_q;
	logic [PORT_W-1:0] hit_port_q;
	logic              hit_own_q;
	logic              rd_vld_s1;

	logic   rd_en, wr_en, match, accept;
	entry_t wr_data, rd_data;

	// result registers
	logic              done_q;
	status_t           status_q, status_d;
	logic              dl_q, dl_d, fl_q, fl_d, ex_q, ex_d, uc_q, uc_d;
	logic [PORT_W-1:0] op_q, op_d;
	logic [TTL_W-1:0]  ot_q, ot_d;
	logic [TTL_W-1:0]  dec;

	fdrp_table u_table (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wp_q),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (idx_q[ADDR_W-1:0]),
		.rd_data (rd_data)
	);

	assign accept = start && !busy;
	assign match  = rd_vld_s1 && (rd_data.flow_id == flow_id_q);
	assign dec    = ttl_q - TTL_W'(1);

	assign wr_data.flow_id  = flow_id_q;
	assign wr_data.hop_port = local_q ? '0 : port_q;
	assign wr_data.own      = local_q;

	always_comb begin
		state_d  = state_q;
		rd_en    = 1'b0;
		wr_en    = 1'b0;
		status_d = ST_NEW;
		dl_d     = 1'b0;
		fl_d     = 1'b0;
		ex_d     = 1'b0;
		uc_d     = 1'b0;
		op_d     = '0;
		ot_d     = '0;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					state_d = S_SCAN;
				end
			end
			S_SCAN: begin
				// one compare per cycle against the entry read on the previous cycle
				if (match) begin
					state_d = S_DECIDE;
				end else if (idx_q < fill_q) begin
					rd_en = 1'b1;
				end else begin
					state_d = S_DECIDE;
				end
			end
			S_DECIDE: begin
				state_d = S_IDLE;
				if (func_q == FUNC_REQUEST) begin
					if (found_q) begin
						status_d = ST_DUP;
					end else begin
						wr_en    = 1'b1;
						status_d = ST_NEW;
						dl_d     = 1'b1;
						fl_d     = (dec != '0);
						ex_d     = !local_q;
						op_d     = local_q ? '0 : port_q;
						ot_d     = dec;
					end
				end else if (!found_q) begin
					status_d = ST_UNKNOWN;
				end else if (hit_own_q) begin
					status_d = ST_LOCAL;
					dl_d     = 1'b1;
				end else begin
					op_d = hit_port_q;
					ot_d = dec;
					if (dec != '0) begin
						status_d = ST_RELAYED;
						uc_d     = 1'b1;
					end else begin
						status_d = ST_EXPIRED;
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			fill_q    <= '0;
			wp_q      <= '0;
			rd_vld_s1 <= 1'b0;
			done_q    <= 1'b0;
		end else begin
			state_q   <= state_d;
			rd_vld_s1 <= rd_en;
			done_q    <= (state_q == S_DECIDE);
			if (wr_en) begin
				wp_q <= (wp_q == ADDR_W'(TABLE_DEPTH - 1)) ? '0 : wp_q + ADDR_W'(1);
				if (fill_q != CNT_W'(TABLE_DEPTH)) begin
					fill_q <= fill_q + CNT_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			func_q    <= func;
			flow_id_q <= flow_id;
			ttl_q     <= ttl;
			local_q   <= from_local;
			port_q    <= sender_port;
			idx_q     <= '0;
			found_q   <= 1'b0;
		end else if (state_q == S_SCAN) begin
			if (match) begin
				found_q    <= 1'b1;
				hit_port_q <= rd_data.hop_port;
				hit_own_q  <= rd_data.own;
			end else if (rd_en) begin
				idx_q <= idx_q + CNT_W'(1);
			end
		end
		if (state_q == S_DECIDE) begin
			status_q <= status_d;
			dl_q     <= dl_d;
			fl_q     <= fl_d;
			ex_q     <= ex_d;
			uc_q     <= uc_d;
			op_q     <= op_d;
			ot_q     <= ot_d;
		end
	end

	assign busy          = (state_q != S_IDLE);
	assign done          = done_q;
	assign status        = status_q;
	assign deliver_local = dl_q;
	assign flood_out     = fl_q;
	assign exclude_valid = ex_q;
	assign unicast_out   = uc_q;
	assign out_port      = op_q;
	assign out_ttl       = ot_q;

endmodule

// File: tb/tb_flood_dedup_reverse_path_router.sv
`timescale 1ns / 100ps
// tb_flood_dedup_reverse_path_router: self-checking bench for the flooding router
// keeps its own flow table to predict each result and checks every done strobe against it
// depends on fdrp_pkg and flood_dedup_reverse_path_router
module tb_flood_dedup_reverse_path_router;
	import fdrp_pkg::*;

	localparam int QUIET_LIMIT  = 2000;
	localparam int DRAIN_CYCLES = 80;
	localparam int RECENT_MAX   = 96;

	typedef struct {
		status_t           status;
		logic              deliver_local;
		logic              flood_out;
		logic              exclude_valid;
		logic              unicast_out;
		logic [PORT_W-1:0] out_port;
		logic [TTL_W-1:0]  out_ttl;
	} route_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                start = 1'b0;
	logic                busy;
	logic                func = FUNC_REQUEST;
	logic [FLOW_W-1:0]   flow_id = '0;
	logic [TTL_W-1:0]    ttl = '0;
	logic                from_local = 1'b0;
	logic [PORT_W-1:0]   sender_port = '0;
	logic                done;
	logic [STATUS_W-1:0] status;
	logic                deliver_local;
	logic                flood_out;
	logic                exclude_valid;
	logic                unicast_out;
	logic [PORT_W-1:0]   out_port;
	logic [TTL_W-1:0]    out_ttl;

	// mirror of the flow table
	logic [FLOW_W-1:0] flow_tab [TABLE_DEPTH];
	logic [PORT_W-1:0] port_tab [TABLE_DEPTH];
	logic              own_tab  [TABLE_DEPTH];
	logic [ADDR_W-1:0] wr_ptr = '0;
	logic [CNT_W-1:0]  fill = '0;

	route_t            route_q[$];
	logic [FLOW_W-1:0] recent_flows[$];
	int                errors = 0;
	int                quiet_cycles = 0;
	bit                no_idle = 1'b0;

	flood_dedup_reverse_path_router dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.func          (func),
		.flow_id       (flow_id),
		.ttl           (ttl),
		.from_local    (from_local),
		.sender_port   (sender_port),
		.done          (done),
		.status        (status),
		.deliver_local (deliver_local),
		.flood_out     (flood_out),
		.exclude_valid (exclude_valid),
		.unicast_out   (unicast_out),
		.out_port      (out_port),
		.out_ttl       (out_ttl)
	);

	always #6 clk = ~clk;

	function automatic route_t predict_route(input logic req_func, input logic [FLOW_W-1:0] id,
		input logic [TTL_W-1:0] hops, input logic loc, input logic [PORT_W-1:0] port);
		route_t           r;
		logic [TTL_W-1:0] dec;
		int               hit;
		dec = hops - TTL_W'(1);
		r = '{ST_NEW, 1'b0, 1'b0, 1'b0, 1'b0, '0, '0};
		hit = -1;
		// only filled entries are searched, lowest index wins
		for (int i = 0; i < int'(fill); i++)
			if (hit < 0 && flow_tab[ADDR_W'(i)] == id)
				hit = i;
		if (req_func == FUNC_REQUEST) begin
			if (hit >= 0) begin
				r.status = ST_DUP;
			end else begin
				flow_tab[wr_ptr] = id;
				own_tab[wr_ptr] = loc;
				port_tab[wr_ptr] = loc ? '0 : port;
				wr_ptr = wr_ptr + ADDR_W'(1);
				if (fill < CNT_W'(TABLE_DEPTH))
					fill = fill + CNT_W'(1);
				r.status = ST_NEW;
				r.deliver_local = 1'b1;
				r.flood_out = (dec != '0);
				r.exclude_valid = !loc;
				r.out_port = loc ? '0 : port;
				r.out_ttl = dec;
			end
		end else begin
			if (hit < 0) begin
				r.status = ST_UNKNOWN;
			end else if (own_tab[ADDR_W'(hit)]) begin
				r.status = ST_LOCAL;
				r.deliver_local = 1'b1;
			end else begin
				r.out_port = port_tab[ADDR_W'(hit)];
				r.out_ttl = dec;
				r.status = (dec != '0) ? ST_RELAYED : ST_EXPIRED;
				r.unicast_out = (dec != '0);
			end
		end
		return r;
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic logic [TTL_W-1:0] pick_ttl();
		case ($urandom_range(0, 7))
			0: return 8'd0;
			1: return 8'd1;
			2: return 8'd2;
			3: return 8'd255;
			default: return TTL_W'($urandom_range(0, 255));
		endcase
	endfunction

	function automatic logic [FLOW_W-1:0] pick_recent();
		return recent_flows[$urandom_range(0, recent_flows.size() - 1)];
	endfunction

	// drives at the falling edge, holds start until the block takes the item
	task automatic send_item(input logic f, input logic [FLOW_W-1:0] id,
		input logic [TTL_W-1:0] hops, input logic loc, input logic [PORT_W-1:0] port);
		int gap;
		gap = no_idle ? 0 : pick_gap();
		if (gap > 0) begin
			start = 1'b0;
			repeat (gap) @(negedge clk);
		end
		func = f;
		flow_id = id;
		ttl = hops;
		from_local = loc;
		sender_port = port;
		start = 1'b1;
		@(posedge clk);
		while (busy !== 1'b0)
			@(posedge clk);
		route_q.push_back(predict_route(f, id, hops, loc, port));
		if (f == FUNC_REQUEST) begin
			recent_flows.push_back(id);
			if (recent_flows.size() > RECENT_MAX)
				void'(recent_flows.pop_front());
		end
		@(negedge clk);
	endtask

	task automatic check_field(input string name, input logic [7:0] exp_v,
		input logic [7:0] act_v);
		if (act_v !== exp_v) begin
			errors++;
			$display("%0t %s mismatch: expected %0h actual %0h", $time, name, exp_v, act_v);
		end
	endtask

	always @(posedge clk) begin : result_check
		route_t want;
		if (done === 1'b1) begin
			if (route_q.size() == 0) begin
				errors++;
				$display("%0t unexpected result: status %0h", $time, status);
			end else begin
				want = route_q.pop_front();
				check_field("status", 8'(want.status), 8'(status));
				check_field("deliver_local", 8'(want.deliver_local), 8'(deliver_local));
				check_field("flood_out", 8'(want.flood_out), 8'(flood_out));
				check_field("exclude_valid", 8'(want.exclude_valid), 8'(exclude_valid));
				check_field("unicast_out", 8'(want.unicast_out), 8'(unicast_out));
				check_field("out_port", 8'(want.out_port), 8'(out_port));
				check_field("out_ttl", want.out_ttl, out_ttl);
			end
		end
	end

	always @(posedge clk) begin
		if ((start === 1'b1 && busy === 1'b0) || done === 1'b1)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles == QUIET_LIMIT) begin
			$display("%0t no handshake for %0d cycles", $time, QUIET_LIMIT);
			$display("FAIL flood_dedup_reverse_path_router");
			$finish;
		end
	end

	task automatic test_directed();
		logic [FLOW_W-1:0] ones;
		ones = '1;
		// empty table, nothing to find
		send_item(FUNC_RESPONSE, '0, 8'd5, 1'b0, 4'd3);
		// ttl zero wraps to 255 and still floods
		send_item(FUNC_REQUEST, '0, 8'd0, 1'b0, 4'd15);
		// local origin with ttl one: delivered, not flooded, port not kept
		send_item(FUNC_REQUEST, ones, 8'd1, 1'b1, 4'd9);
		send_item(FUNC_REQUEST, '0, 8'd200, 1'b1, 4'd0);
		send_item(FUNC_REQUEST, ones, 8'd0, 1'b0, 4'd4);
		send_item(FUNC_RESPONSE, '0, 8'd1, 1'b0, 4'd2);
		send_item(FUNC_RESPONSE, '0, 8'd255, 1'b1, 4'd7);
		send_item(FUNC_RESPONSE, '0, 8'd0, 1'b0, 4'd0);
		send_item(FUNC_RESPONSE, ones, 8'd1, 1'b0, 4'd5);
		send_item(FUNC_RESPONSE, ones, 8'd0, 1'b1, 4'd15);
		send_item(FUNC_REQUEST, 64'h8000_0000_0000_0001, 8'd255, 1'b0, 4'd0);
		send_item(FUNC_REQUEST, 64'h7fff_ffff_ffff_fffe, 8'd2, 1'b0, 4'd10);
		send_item(FUNC_RESPONSE, 64'h7fff_ffff_ffff_fffe, 8'd2, 1'b0, 4'd1);
		send_item(FUNC_RESPONSE, 64'h8000_0000_0000_0001, 8'd1, 1'b0, 4'd6);
		// near miss on a stored id
		send_item(FUNC_RESPONSE, 64'h8000_0000_0000_0000, 8'd9, 1'b0, 4'd8);
		send_item(FUNC_REQUEST, 64'h1, 8'd0, 1'b1, 4'd15);
		send_item(FUNC_RESPONSE, 64'h1, 8'd3, 1'b0, 4'd2);
	endtask

	// fills the table past its depth so the oldest flows are overwritten
	task automatic test_table_wrap();
		logic [FLOW_W-1:0] id;
		no_idle = 1'b1;
		for (int i = 0; i < TABLE_DEPTH + 8; i++) begin
			id = {16'hc0de, 16'(i), $urandom};
			send_item(FUNC_REQUEST, id, pick_ttl(), i[0], 4'($urandom));
		end
		no_idle = 1'b0;
		for (int i = 0; i < 16; i++)
			send_item(FUNC_RESPONSE, recent_flows[$urandom_range(0, recent_flows.size() - 1)],
				pick_ttl(), 1'b0, 4'($urandom));
	endtask

	task automatic test_random_traffic(input int count);
		int                kind;
		logic              f;
		logic [FLOW_W-1:0] id;
		for (int n = 0; n < count; n++) begin
			// now and then a burst with no gaps at all
			if (n % 50 == 0)
				no_idle = ($urandom_range(0, 3) == 0);
			kind = $urandom_range(0, 99);
			if (kind < 35) begin
				f = FUNC_REQUEST;
				id = {$urandom, $urandom};
			end else if (kind < 50) begin
				f = FUNC_REQUEST;
				id = pick_recent();
			end else if (kind < 90) begin
				f = FUNC_RESPONSE;
				id = pick_recent();
			end else if (kind < 95) begin
				f = FUNC_RESPONSE;
				id = {$urandom, $urandom};
			end else begin
				// small ids collide often
				f = $urandom_range(0, 1) ? FUNC_RESPONSE : FUNC_REQUEST;
				id = FLOW_W'($urandom_range(0, 15));
			end
			send_item(f, id, pick_ttl(), 1'($urandom_range(0, 1)), 4'($urandom));
		end
		no_idle = 1'b0;
	endtask

	initial begin
		repeat (4) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_directed();
		test_table_wrap();
		test_random_traffic(1000);
		start = 1'b0;
		while (route_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("PASS flood_dedup_reverse_path_router");
		else
			$display("FAIL flood_dedup_reverse_path_router");
		$finish;
	end

endmodule
